### src/fla_pkg.sv
package fla_pkg;

    localparam int ARENA_UNITS_DEF = 1024;
    localparam int UNIT_BYTES_DEF  = 8;

    localparam int REQ_W      = 13;
    localparam int BADDR_W    = 10;
    localparam int PADDR_W    = 10;
    localparam int NEED_W     = 15;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    typedef struct packed {
        logic next_en;
        logic size_en;
    } t_mem_we;

endpackage

### src/fla_mem.sv
module fla_mem
    import fla_pkg::*;
#(
    parameter int ARENA_UNITS = ARENA_UNITS_DEF,
    localparam int IW = $clog2(ARENA_UNITS),
    localparam int AW = $clog2(ARENA_UNITS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  t_mem_we       i_we,
    input  logic [AW-1:0] i_wr_next,
    input  logic [AW-1:0] i_wr_size,
    output logic [AW-1:0] o_rd_next,
    output logic [AW-1:0] o_rd_size
);

    logic [AW-1:0] r_next_mem [ARENA_UNITS];
    logic [AW-1:0] r_size_mem [ARENA_UNITS];
    logic [AW-1:0] r_rd_next;
    logic [AW-1:0] r_rd_size;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_next <= r_next_mem[i_rd_addr];
            r_rd_size <= r_size_mem[i_rd_addr];
        end
        if (i_we.next_en) begin
            r_next_mem[i_wr_addr] <= i_wr_next;
        end
        if (i_we.size_en) begin
            r_size_mem[i_wr_addr] <= i_wr_size;
        end
    end

    assign o_rd_next = r_rd_next;
    assign o_rd_size = r_rd_size;

endmodule

### src/fla_need.sv
module fla_need
    import fla_pkg::*;
#(
    parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [REQ_W-1:0]  i_bytes,
    output logic [NEED_W-1:0] o_need
);

    localparam int XW    = REQ_W + 1;
    localparam int SH    = 18;
    localparam int RECIP = (1 << SH) / UNIT_BYTES;

    logic [XW-1:0]     x;
    logic [31:0]       prod;
    logic [XW-1:0]     r_x;
    logic [XW-1:0]     r_q0;
    logic [31:0]       back;
    logic [31:0]       rem;
    logic [XW-1:0]     q;
    logic [NEED_W-1:0] r_need;

    assign x    = XW'(i_bytes) + XW'(UNIT_BYTES - 1);
    assign prod = 32'(x) * 32'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x  <= x;
            r_q0 <= prod[SH+XW-1:SH];
        end
    end

    assign back = 32'(r_q0) * 32'(UNIT_BYTES);
    assign rem  = 32'(r_x) - back;
    assign q    = (rem >= 32'(UNIT_BYTES)) ? r_q0 + XW'(1) : r_q0;

    always_ff @(posedge i_clk) begin
        r_need <= NEED_W'(q) + NEED_W'(1);
    end

    assign o_need = r_need;

endmodule

### src/fla_ctrl.sv
module fla_ctrl
    import fla_pkg::*;
#(
    parameter int ARENA_UNITS = ARENA_UNITS_DEF,
    localparam int IW = $clog2(ARENA_UNITS),
    localparam int AW = $clog2(ARENA_UNITS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [BADDR_W-1:0] i_block_addr,
    input  logic [NEED_W-1:0]  i_need,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output logic               o_res_status,
    output logic [PADDR_W-1:0] o_res_addr,
    output logic               o_rd_en,
    output logic [IW-1:0]      o_rd_addr,
    input  logic [AW-1:0]      i_rd_next,
    input  logic [AW-1:0]      i_rd_size,
    output logic [IW-1:0]      o_wr_addr,
    output t_mem_we            o_we,
    output logic [AW-1:0]      o_wr_next,
    output logic [AW-1:0]      o_wr_size
);

    localparam int KW = AW + 1;
    localparam int WALK_LIMIT = ARENA_UNITS + 2;
    localparam int SW = $clog2(WALK_LIMIT);
    localparam logic [AW-1:0] SENT = AW'(ARENA_UNITS);
    localparam logic [SW-1:0] STEP_LAST = SW'(WALK_LIMIT - 1);

    typedef enum logic [10:0] {
        S_INIT    = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_A_FIRST = 11'b000_0000_0100,
        S_A_CHK   = 11'b000_0000_1000,
        S_A_CARVE = 11'b000_0001_0000,
        S_R_WALK  = 11'b000_0010_0000,
        S_R_RDN   = 11'b000_0100_0000,
        S_R_W1    = 11'b000_1000_0000,
        S_R_W2    = 11'b001_0000_0000,
        S_DONE    = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    function automatic logic [KW-1:0] key_of(input logic [AW-1:0] x);
        key_of = (x < SENT) ? KW'(x) + KW'(1) : '0;
    endfunction

    function automatic logic [AW-1:0] norm_idx(input logic [KW-1:0] x);
        norm_idx = (x < KW'(ARENA_UNITS)) ? x[AW-1:0] : SENT;
    endfunction

    function automatic logic [PADDR_W-1:0] pay_addr(input logic [AW-1:0] x);
        logic [31:0] t;
        t = 32'(x) + 32'd1;
        pay_addr = t[PADDR_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [AW-1:0]      r_p, n_p;
    logic [AW-1:0]      r_prev, n_prev;
    logic [AW-1:0]      r_n, n_n;
    logic [SW-1:0]      r_step, n_step;
    logic [AW-1:0]      r_rover, n_rover;
    logic [AW-1:0]      r_sent_next, n_sent_next;
    logic [AW-1:0]      r_psize, n_psize;
    logic [AW-1:0]      r_bp, n_bp;
    logic [AW-1:0]      r_bsize, n_bsize;
    logic [AW-1:0]      r_bnext, n_bnext;
    logic               r_res_status, n_res_status;
    logic [PADDR_W-1:0] r_res_addr, n_res_addr;
    logic               r_rd_sent, n_rd_sent;

    logic [AW-1:0]      node_next;
    logic [AW-1:0]      node_size;
    logic [AW-1:0]      rd_full;
    logic [AW-1:0]      wr_full;
    logic               accept;
    logic               rel_ok;
    logic [31:0]        rel_bp32;

    assign node_next = r_rd_sent ? r_sent_next : i_rd_next;
    assign node_size = r_rd_sent ? '0 : i_rd_size;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign rel_bp32 = 32'(i_block_addr) - 32'd1;
    assign rel_ok = (i_block_addr != '0) && (rel_bp32 < 32'(ARENA_UNITS));
    assign o_rd_addr = rd_full[IW-1:0];
    assign o_wr_addr = wr_full[IW-1:0];

    always_comb begin
        logic [KW-1:0] kp;
        logic [KW-1:0] kn;
        logic [KW-1:0] kb;
        logic [KW-1:0] sum;
        logic [31:0]   sz32;
        logic [31:0]   need32;
        n_state      = r_state;
        n_p          = r_p;
        n_prev       = r_prev;
        n_n          = r_n;
        n_step       = r_step;
        n_rover      = r_rover;
        n_sent_next  = r_sent_next;
        n_psize      = r_psize;
        n_bp         = r_bp;
        n_bsize      = r_bsize;
        n_bnext      = r_bnext;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_rd_sent    = r_rd_sent;
        o_rd_en      = 1'b0;
        rd_full      = '0;
        o_we         = '0;
        wr_full      = '0;
        o_wr_next    = '0;
        o_wr_size    = '0;
        o_res_valid  = 1'b0;
        kp = key_of(r_p);
        kn = key_of(node_next);
        kb = key_of(r_bp);
        sum = '0;
        sz32 = 32'(node_size);
        need32 = 32'(i_need);
        unique case (r_state)
            S_INIT: begin
                o_we      = '{next_en: 1'b1, size_en: 1'b1};
                wr_full   = '0;
                o_wr_next = SENT;
                o_wr_size = SENT;
                n_state   = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_step    = '0;
                    n_p       = r_rover;
                    o_rd_en   = 1'b1;
                    rd_full   = r_rover;
                    n_rd_sent = (r_rover >= SENT);
                    if (i_cmd == CMD_ALLOC) begin
                        n_state = S_A_FIRST;
                    end else if (rel_ok) begin
                        n_bp    = rel_bp32[AW-1:0];
                        n_state = S_R_WALK;
                    end else begin
                        n_res_status = ST_DONE;
                        n_res_addr   = '0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_A_FIRST: begin
                n_prev    = r_rover;
                n_p       = node_next;
                o_rd_en   = 1'b1;
                rd_full   = node_next;
                n_rd_sent = (node_next >= SENT);
                n_state   = S_A_CHK;
            end
            S_A_CHK: begin
                if (sz32 >= need32) begin
                    n_rover = r_prev;
                    n_res_status = ST_DONE;
                    if (sz32 == need32) begin
                        if (r_prev < SENT) begin
                            o_we.next_en = 1'b1;
                            wr_full      = r_prev;
                            o_wr_next    = norm_idx(KW'(node_next));
                        end else begin
                            n_sent_next = norm_idx(KW'(node_next));
                        end
                        n_res_addr = pay_addr(r_p);
                        n_state    = S_DONE;
                    end else begin
                        o_we.size_en = 1'b1;
                        wr_full      = r_p;
                        o_wr_size    = AW'(sz32 - need32);
                        sum          = KW'(r_p) + KW'(AW'(sz32 - need32));
                        n_p          = norm_idx(sum);
                        n_state      = S_A_CARVE;
                    end
                end else if (r_p == r_rover || r_step == STEP_LAST) begin
                    n_res_status = ST_NO_SPACE;
                    n_res_addr   = '0;
                    n_state      = S_DONE;
                end else begin
                    n_prev    = r_p;
                    n_p       = node_next;
                    n_step    = r_step + SW'(1);
                    o_rd_en   = 1'b1;
                    rd_full   = node_next;
                    n_rd_sent = (node_next >= SENT);
                end
            end
            S_A_CARVE: begin
                if (r_p < SENT) begin
                    o_we.size_en = 1'b1;
                    wr_full      = r_p;
                    o_wr_size    = AW'(i_need);
                end
                n_res_addr = pay_addr(r_p);
                n_state    = S_DONE;
            end
            S_R_WALK: begin
                if ((kb > kp && kb < kn) || (kp >= kn && (kb > kp || kb < kn))) begin
                    n_n       = node_next;
                    n_psize   = node_size;
                    o_rd_en   = 1'b1;
                    rd_full   = r_bp;
                    n_rd_sent = 1'b0;
                    n_state   = S_R_RDN;
                end else if (r_step == STEP_LAST) begin
                    n_res_status = ST_DONE;
                    n_res_addr   = '0;
                    n_state      = S_DONE;
                end else begin
                    n_p       = node_next;
                    n_step    = r_step + SW'(1);
                    o_rd_en   = 1'b1;
                    rd_full   = node_next;
                    n_rd_sent = (node_next >= SENT);
                end
            end
            S_R_RDN: begin
                n_bsize   = i_rd_size;
                o_rd_en   = 1'b1;
                rd_full   = r_n;
                n_rd_sent = (r_n >= SENT);
                n_state   = S_R_W1;
            end
            S_R_W1: begin
                sum     = KW'(r_bp) + KW'(r_bsize);
                wr_full = r_bp;
                o_we.next_en = 1'b1;
                if (r_n < SENT && sum == KW'(r_n)) begin
                    o_we.size_en = 1'b1;
                    o_wr_size    = r_bsize + node_size;
                    o_wr_next    = norm_idx(KW'(node_next));
                    n_bsize      = r_bsize + node_size;
                    n_bnext      = norm_idx(KW'(node_next));
                end else begin
                    o_wr_next = r_n;
                    n_bnext   = r_n;
                end
                n_state = S_R_W2;
            end
            S_R_W2: begin
                sum     = KW'(r_p) + KW'(r_psize);
                wr_full = r_p;
                if (r_p < SENT && sum == KW'(r_bp)) begin
                    o_we      = '{next_en: 1'b1, size_en: 1'b1};
                    o_wr_size = r_psize + r_bsize;
                    o_wr_next = r_bnext;
                end else if (r_p < SENT) begin
                    o_we.next_en = 1'b1;
                    o_wr_next    = r_bp;
                end else begin
                    n_sent_next = r_bp;
                end
                n_rover      = r_p;
                n_res_status = ST_DONE;
                n_res_addr   = '0;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_step      <= '0;
            r_rover     <= SENT;
            r_sent_next <= '0;
            r_rd_sent   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_rover     <= n_rover;
            r_sent_next <= n_sent_next;
            r_rd_sent   <= n_rd_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p          <= n_p;
        r_prev       <= n_prev;
        r_n          <= n_n;
        r_psize      <= n_psize;
        r_bp         <= n_bp;
        r_bsize      <= n_bsize;
        r_bnext      <= n_bnext;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
    end

    assign o_res_status = r_res_status;
    assign o_res_addr   = r_res_addr;

    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rd_en && (o_we.next_en || o_we.size_en)))
        else $error("memory read and write in the same cycle");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_step) < WALK_LIMIT)
        else $error("walk step counter out of range");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we.next_en || o_we.size_en) |->
            (r_state == S_INIT || r_state == S_A_CHK || r_state == S_A_CARVE ||
             r_state == S_R_W1 || r_state == S_R_W2))
        else $error("memory write outside an update state");

    a_carve_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_CARVE) |-> $past(r_state == S_A_CHK))
        else $error("carve without a fit check");

    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_state == S_IDLE))
        else $error("result issued without return to idle");

endmodule

### src/free_list_allocator.sv
// Allocate: S_IDLE, S_A_FIRST, then S_A_CHK per list node until a fit; a carve adds S_A_CARVE.
// Release: S_R_WALK per list node to the insertion point, then S_R_RDN, S_R_W1 and S_R_W2.
// One item in flight; one list node read per cycle during a walk.
// The output register lets the next item be accepted while a result waits.
// Synchronous active-low reset; after reset S_INIT rewrites entry 0 as the whole-arena block.
module free_list_allocator
    import fla_pkg::*;
#(
    parameter int ARENA_UNITS = ARENA_UNITS_DEF,
    parameter int UNIT_BYTES  = UNIT_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_bytes, block_addr
    input  logic                  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_addr
    output logic                  m_axis_tuser    // status
);

    localparam int IW = $clog2(ARENA_UNITS);
    localparam int AW = $clog2(ARENA_UNITS + 1);

    logic [REQ_W-1:0]   req_bytes;
    logic [BADDR_W-1:0] blk_addr;
    logic [NEED_W-1:0]  need;
    logic               accept;
    logic               res_ready;
    logic               res_valid;
    logic               res_status;
    logic [PADDR_W-1:0] res_addr;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic [AW-1:0]      rd_next;
    logic [AW-1:0]      rd_size;
    logic [IW-1:0]      wr_addr;
    t_mem_we            we;
    logic [AW-1:0]      wr_next;
    logic [AW-1:0]      wr_size;

    logic               r_out_valid;
    logic               r_out_status;
    logic [PADDR_W-1:0] r_out_addr;

    assign req_bytes = s_axis_tdata[REQ_W-1:0];
    assign blk_addr  = s_axis_tdata[REQ_W+BADDR_W-1:REQ_W];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign res_ready = !r_out_valid || m_axis_tready;

    fla_need #(
        .UNIT_BYTES(UNIT_BYTES)
    ) u_need (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_bytes(req_bytes),
        .o_need (need)
    );

    fla_mem #(
        .ARENA_UNITS(ARENA_UNITS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .i_wr_addr(wr_addr),
        .i_we     (we),
        .i_wr_next(wr_next),
        .i_wr_size(wr_size),
        .o_rd_next(rd_next),
        .o_rd_size(rd_size)
    );

    fla_ctrl #(
        .ARENA_UNITS(ARENA_UNITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_block_addr(blk_addr),
        .i_need      (need),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res_status(res_status),
        .o_res_addr  (res_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_next   (rd_next),
        .i_rd_size   (rd_size),
        .o_wr_addr   (wr_addr),
        .o_we        (we),
        .o_wr_next   (wr_next),
        .o_wr_size   (wr_size)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_status <= res_status;
            r_out_addr   <= res_addr;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - PADDR_W){1'b0}}, r_out_addr};
    assign m_axis_tuser  = r_out_status;

endmodule

### verif/free_list_allocator_checker.sv
`timescale 1ns / 100ps
module free_list_allocator_checker
    import fla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // request_bytes, block_addr
    input  logic                  s_axis_tuser,   // cmd
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_addr
    input  logic                  m_axis_tuser,   // status
    output int                    o_failures,
    output int                    o_outstanding
);

    localparam int UNITS      = ARENA_UNITS_DEF;
    localparam int SENTINEL   = UNITS;
    localparam int WALK_STEPS = UNITS + 2;
    localparam int PRINT_CAP  = 40;

    typedef logic [10:0] t_node;

    typedef struct packed {
        logic               status;
        logic [PADDR_W-1:0] addr;
    } t_grant;

    t_node  link_tab [UNITS];
    t_node  span_tab [UNITS];
    t_node  head_link;
    t_node  rover;
    t_grant grants_due [$];
    t_grant want;

    function automatic t_node clip(longint unsigned x);
        return (x < UNITS) ? t_node'(x) : t_node'(SENTINEL);
    endfunction

    function automatic int unsigned rank(t_node x);
        return (x < SENTINEL) ? x + 1 : 0;
    endfunction

    function automatic t_node link_of(t_node x);
        return (x < SENTINEL) ? link_tab[x] : head_link;
    endfunction

    function automatic int unsigned span_of(t_node x);
        return (x < SENTINEL) ? span_tab[x] : 0;
    endfunction

    function automatic void set_link(t_node x, longint unsigned v);
        if (x < SENTINEL) begin
            link_tab[x] = clip(v);
        end else begin
            head_link = clip(v);
        end
    endfunction

    function automatic void set_span(t_node x, int unsigned v);
        if (x < SENTINEL) begin
            span_tab[x] = t_node'(v);
        end
    endfunction

    function automatic void clear_arena();
        foreach (link_tab[i]) begin
            link_tab[i] = '0;
            span_tab[i] = '0;
        end
        link_tab[0] = t_node'(SENTINEL);
        span_tab[0] = t_node'(UNITS);
        head_link   = '0;
        rover       = t_node'(SENTINEL);
    endfunction

    function automatic t_grant alloc_grant(logic [REQ_W-1:0] bytes);
        int unsigned need_units;
        int unsigned sz;
        int unsigned step;
        t_node       prev;
        t_node       p;
        need_units = (int'(bytes) + UNIT_BYTES_DEF - 1) / UNIT_BYTES_DEF + 1;
        prev = rover;
        p    = link_of(prev);
        for (step = 0; step < WALK_STEPS; step++) begin
            sz = span_of(p);
            if (sz >= need_units) begin
                if (sz == need_units) begin
                    set_link(prev, link_of(p));
                end else begin
                    // carve the tail end
                    sz = sz - need_units;
                    set_span(p, sz);
                    p = clip(p + sz);
                    set_span(p, need_units);
                end
                rover = prev;
                return '{ST_DONE, PADDR_W'(p + 1)};
            end
            if (p == rover) begin
                break;
            end
            prev = p;
            p    = link_of(p);
        end
        return '{ST_NO_SPACE, '0};
    endfunction

    function automatic void free_block(logic [BADDR_W-1:0] addr);
        t_node       bp;
        t_node       p;
        t_node       n;
        int unsigned kb;
        int unsigned kp;
        int unsigned kn;
        int unsigned step;
        bit          found;
        found = 1'b0;
        if (addr == '0) begin
            return;
        end
        bp = addr - 1;
        kb = rank(bp);
        p  = rover;
        for (step = 0; step < WALK_STEPS; step++) begin
            n  = link_of(p);
            kp = rank(p);
            kn = rank(n);
            if ((kb > kp && kb < kn) || (kp >= kn && (kb > kp || kb < kn))) begin
                found = 1'b1;
                break;
            end
            p = n;
        end
        if (!found) begin
            return;
        end
        n = link_of(p);
        if (n < SENTINEL && bp + span_of(bp) == n) begin
            set_span(bp, span_of(bp) + span_of(n));
            set_link(bp, link_of(n));
        end else begin
            set_link(bp, n);
        end
        if (p < SENTINEL && p + span_of(p) == bp) begin
            set_span(p, span_of(p) + span_of(bp));
            set_link(p, link_of(bp));
        end else begin
            set_link(p, bp);
        end
        rover = p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_arena();
            grants_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (grants_due.size() == 0) begin
                    o_failures++;
                    if (o_failures <= PRINT_CAP) begin
                        $error("unexpected item: status %0d payload_addr %0d",
                               m_axis_tuser, m_axis_tdata);
                    end
                end else begin
                    want = grants_due.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        o_failures++;
                        if (o_failures <= PRINT_CAP) begin
                            $error("status: expected %0d, got %0d",
                                   want.status, m_axis_tuser);
                        end
                    end
                    if (m_axis_tdata !== OUT_DATA_W'(want.addr)) begin
                        o_failures++;
                        if (o_failures <= PRINT_CAP) begin
                            $error("payload_addr: expected %0d, got %0d",
                                   want.addr, m_axis_tdata);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_ALLOC) begin
                    grants_due.push_back(alloc_grant(s_axis_tdata[REQ_W-1:0]));
                end else begin
                    free_block(s_axis_tdata[REQ_W +: BADDR_W]);
                    grants_due.push_back('{ST_DONE, '0});
                end
            end
        end
        o_outstanding = grants_due.size();
    end

endmodule

### verif/free_list_allocator_test.sv
`timescale 1ns / 100ps
module free_list_allocator_test;
    import fla_pkg::*;

    localparam int CYCLE_LIMIT       = 6_000_000;
    localparam int RANDOM_ITEMS      = 1250;
    localparam int HOLD_AFTER_ITEMS  = 300;
    localparam int SINK_HOLD_CYCLES  = 400;
    localparam int PAUSE_AFTER_ITEMS = 700;
    localparam int TAIL_CYCLES       = 20;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_CYCLIC} t_sink_mode;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // request_bytes, block_addr
    logic                  s_axis_tuser  = 1'b0; // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // payload_addr
    logic                  m_axis_tuser;         // status

    logic               s_took = 1'b0;
    logic               cmds_in_flight [$];
    logic [PADDR_W-1:0] live_blocks [$];
    int unsigned        items_accepted = 0;
    int unsigned        cycles_run     = 0;
    int                 failures;
    int                 outstanding;

    always #2 i_clk = ~i_clk;

    free_list_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    free_list_allocator_checker grant_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        s_took     <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready && cmds_in_flight.size() != 0) begin
                if (cmds_in_flight.pop_front() == CMD_ALLOC && m_axis_tuser == ST_DONE
                        && m_axis_tdata[PADDR_W-1:0] != '0) begin
                    live_blocks.push_back(m_axis_tdata[PADDR_W-1:0]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cmds_in_flight.push_back(s_axis_tuser);
                items_accepted++;
            end
        end
    end

    initial begin : watchdog
        wait (cycles_run == CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    task automatic offer(logic cmd, logic [REQ_W-1:0] bytes, logic [BADDR_W-1:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, addr, bytes};
        do @(negedge i_clk); while (!s_took);
    endtask

    task automatic pause_sender(int unsigned n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (cmds_in_flight.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random(output bit counted);
        int unsigned        roll;
        int unsigned        slot;
        logic [REQ_W-1:0]   bytes;
        logic [BADDR_W-1:0] addr;
        roll    = $urandom_range(99);
        bytes   = $urandom_range(8191);
        addr    = $urandom_range(1023);
        counted = 1'b1;
        if (live_blocks.size() != 0 && (roll < 42 || (live_blocks.size() > 60 && roll < 70))) begin
            slot = $urandom_range(live_blocks.size() - 1);
            addr = live_blocks[slot];
            live_blocks.delete(slot);
            offer(CMD_RELEASE, bytes, addr);
        end else if (roll >= 97) begin
            counted = 1'b0;
            offer(CMD_RELEASE, bytes, '0);
        end else begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                bytes = $urandom_range(63);
            end else if (roll < 90) begin
                bytes = $urandom_range(1023, 64);
            end else if (roll < 98) begin
                bytes = $urandom_range(4095, 1024);
            end else begin
                bytes = $urandom_range(8191, 4096);
            end
            offer(CMD_ALLOC, bytes, addr);
        end
    endtask

    initial begin : sink
        t_sink_mode  mode;
        int unsigned span;
        int unsigned phase;
        bit          held;
        held  = 1'b0;
        phase = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && items_accepted >= HOLD_AFTER_ITEMS) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
            end
            mode = t_sink_mode'($urandom_range(3));
            span = $urandom_range(96, 16);
            repeat (span) begin
                case (mode)
                    SINK_OPEN:   m_axis_tready <= 1'b1;
                    SINK_COIN:   m_axis_tready <= 1'($urandom_range(1));
                    SINK_SPARSE: m_axis_tready <= ($urandom_range(3) == 0);
                    default:     m_axis_tready <= (phase % 3 != 2);
                endcase
                phase++;
                @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned        taken;
        int unsigned        burst;
        int unsigned        slot;
        bit                 counted;
        bit                 paused;
        logic [PADDR_W-1:0] victim;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // take the whole arena, fail on an empty list, give it back
        offer(CMD_ALLOC, 13'd8184, '0);
        offer(CMD_ALLOC, 13'd0, '1);
        offer(CMD_RELEASE, '1, 10'd1);
        // zero-byte requests; the first lands on the last unit and wraps to 0
        offer(CMD_ALLOC, 13'd0, '0);
        offer(CMD_ALLOC, 13'd0, '0);
        offer(CMD_ALLOC, 13'd8191, '0);
        offer(CMD_ALLOC, 13'd1, '0);
        offer(CMD_RELEASE, '0, 10'd1023);
        offer(CMD_RELEASE, '0, 10'd0);
        // merge with both neighbours
        offer(CMD_RELEASE, '0, 10'd1021);
        offer(CMD_ALLOC, 13'd8176, '0);
        offer(CMD_RELEASE, '0, 10'd1);
        drain();
        live_blocks.delete();

        taken  = 0;
        paused = 1'b0;
        while (taken < RANDOM_ITEMS) begin
            burst = $urandom_range(40, 1);
            repeat (burst) begin
                send_random(counted);
                taken += counted;
            end
            if (!paused && taken >= PAUSE_AFTER_ITEMS) begin
                paused = 1'b1;
                drain();
            end else if ($urandom_range(3) != 0) begin
                pause_sender($urandom_range(12, 1));
            end
        end
        drain();

        // release one block twice, then keep going on the corrupt list
        if (live_blocks.size() != 0) begin
            slot   = $urandom_range(live_blocks.size() - 1);
            victim = live_blocks[slot];
            live_blocks.delete(slot);
            offer(CMD_RELEASE, '0, victim);
            offer(CMD_RELEASE, '0, victim);
            repeat (10) send_random(counted);
        end
        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (failures == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
